[hw/rtl/tplm_pkg.sv]
// shared constants and codes for the tolerance peak list merge
package tplm_pkg;

  localparam int LIST_CAPACITY_DEF = 8192;
  localparam int ENVELOPE_MAX_DEF  = 32;

  localparam int MASS_W    = 32;
  localparam int INT_W     = 32;
  localparam int MINTOL_W  = 20;
  localparam int RIDX_W    = 13;
  localparam int PCNT_W    = 14;
  localparam int DIV_NUM_W = 2 * MASS_W;
  localparam int DIV_DEN_W = INT_W + 1;

  localparam logic [MASS_W-1:0]   PPM_RESET    = 32'd42950;
  localparam logic [MINTOL_W-1:0] MINTOL_RESET = 20'd524;

  localparam logic [1:0] OP_PEAK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_ENV_LONG = 2'd3;

  localparam logic REG_PPM_FACTOR    = 1'b0;
  localparam logic REG_MIN_TOLERANCE = 1'b1;

endpackage

[hw/rtl/tplm_div.sv]
// restoring divider, one quotient bit per cycle, for centroid masses
module tplm_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tplm_pkg::DIV_NUM_W-1:0]  numer,
  input  logic [tplm_pkg::DIV_DEN_W-1:0]  denom,
  output logic                            done,
  output logic [tplm_pkg::MASS_W-1:0]     quot
);
  import tplm_pkg::*;

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_NUM_W-1:0]   num_r, num_nxt;
  logic [DIV_DEN_W:0]     rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0]   den_r, den_nxt;
  logic [DIV_DEN_W:0]     shifted;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    shifted  = {rem_r[DIV_DEN_W-1:0], num_r[DIV_NUM_W-1]};
    if (start) begin
      cnt_nxt = CW'(DIV_NUM_W);
      num_nxt = numer;
      rem_nxt = '0;
      den_nxt = denom;
    end else if (cnt_r != '0) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        num_nxt = {num_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r[MASS_W-1:0];

endmodule

[hw/rtl/tolerance_peak_list_merge.sv]
// top level: stored peak list, envelope buffer and merge sequencer
//
// Input beats carry one operation: an envelope peak, a read of one stored
// peak, or a clear. Every accepted beat gives exactly one result beat with a
// status, the stored peak count and, for a read, the peak itself.
// in_stall is high from the accepted beat until its result has been loaded
// into the output register; one operation is worked on at a time.
// A plain peak, a clear or a rejected read goes to S_FIN; a read via S_RD.
// The last peak of an envelope starts a merge run by one sequencer around
// the list memory port, a shared 32x32 multiplier and a bit-serial divider:
//   append / prepend: write the envelope behind the list or, for prepend,
//            at its head after shifting the stored list up by n
//   overlap: search for the start, merge list and envelope into scratch,
//            passing closer stored peaks and combining each near pair,
//            then copy the merged run back into the list.
// Synchronous reset empties the list and the envelope buffer and restores
// the tolerance registers; memory contents are not cleared.
// While out_stall is high the result beat holds; one more beat may be taken
// and worked on, and its result then waits until the output register frees.
// Configuration writes (cfg_we) are taken at any edge outside reset.
module tolerance_peak_list_merge #(
  parameter int LIST_CAPACITY = tplm_pkg::LIST_CAPACITY_DEF,
  parameter int ENVELOPE_MAX  = tplm_pkg::ENVELOPE_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [tplm_pkg::MASS_W-1:0]   in_peak_mass,
  input  logic [tplm_pkg::INT_W-1:0]    in_peak_intensity,
  input  logic                          in_last_of_envelope,
  input  logic [tplm_pkg::RIDX_W-1:0]   in_read_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [tplm_pkg::PCNT_W-1:0]   out_point_count,
  output logic [tplm_pkg::MASS_W-1:0]   out_point_mass,
  output logic [tplm_pkg::INT_W-1:0]    out_point_intensity,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [tplm_pkg::MASS_W-1:0]   cfg_data
);
  import tplm_pkg::*;

  localparam int ADDR_W = $clog2(LIST_CAPACITY);
  localparam int CNT_W  = $clog2(LIST_CAPACITY + 1);
  localparam int ENV_AW = $clog2(ENVELOPE_MAX);
  localparam int ENV_CW = $clog2(ENVELOPE_MAX + 1);
  localparam int ENT_W  = MASS_W + INT_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD     = 5'd1;
  localparam logic [4:0] S_TOL1   = 5'd2;
  localparam logic [4:0] S_TOL2   = 5'd3;
  localparam logic [4:0] S_CHK1   = 5'd4;
  localparam logic [4:0] S_CHK2   = 5'd5;
  localparam logic [4:0] S_APP_R  = 5'd6;
  localparam logic [4:0] S_APP_W  = 5'd7;
  localparam logic [4:0] S_PRE_R  = 5'd8;
  localparam logic [4:0] S_PRE_W  = 5'd9;
  localparam logic [4:0] S_SCAN_R = 5'd10;
  localparam logic [4:0] S_SCAN_U = 5'd11;
  localparam logic [4:0] S_M_INIT = 5'd12;
  localparam logic [4:0] S_M_HEAD = 5'd13;
  localparam logic [4:0] S_M_DEC  = 5'd14;
  localparam logic [4:0] S_M_NEAR = 5'd15;
  localparam logic [4:0] S_CMB0   = 5'd16;
  localparam logic [4:0] S_CMB1   = 5'd17;
  localparam logic [4:0] S_CMB2   = 5'd18;
  localparam logic [4:0] S_CMB3   = 5'd19;
  localparam logic [4:0] S_TAILE  = 5'd20;
  localparam logic [4:0] S_TAILL  = 5'd21;
  localparam logic [4:0] S_CP_R   = 5'd22;
  localparam logic [4:0] S_CP_W   = 5'd23;
  localparam logic [4:0] S_FIN    = 5'd24;

  // memories
  logic [ENT_W-1:0] list_mem [LIST_CAPACITY];
  logic [ENT_W-1:0] scr_mem  [LIST_CAPACITY];
  logic [ENT_W-1:0] env_mem  [ENVELOPE_MAX];
  logic [ENT_W-1:0] list_q, scr_q, env_q;

  logic [ADDR_W-1:0] list_raddr, list_waddr, scr_raddr, scr_waddr;
  logic [ENT_W-1:0]  list_wdata, scr_wdata;
  logic              list_we, scr_we, env_we;
  logic [ENV_AW-1:0] env_raddr, env_waddr;

  // control and datapath registers
  logic [4:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ENV_CW-1:0]   env_cnt_r, env_cnt_nxt;
  logic [ENV_CW-1:0]   n_r, n_nxt;
  logic [MASS_W-1:0]   first_r, first_nxt, elast_r, elast_nxt, tol_r, tol_nxt;
  logic [CNT_W-1:0]    base_r, base_nxt, k_r, k_nxt, start_r, start_nxt;
  logic [CNT_W-1:0]    p1_r, p1_nxt, len_r, len_nxt;
  logic [ENV_CW-1:0]   p2_r, p2_nxt;
  logic [MASS_W-1:0]   lm_r, lm_nxt, em_r, em_nxt, lo_r, lo_nxt;
  logic [INT_W-1:0]    li_r, li_nxt, ei_r, ei_nxt;
  logic [INT_W:0]      sum_r, sum_nxt;
  logic [1:0]          res_st_r, res_st_nxt;
  logic [MASS_W-1:0]   res_m_r, res_m_nxt;
  logic [INT_W-1:0]    res_i_r, res_i_nxt;
  logic [MASS_W-1:0]   mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [2*MASS_W-1:0] prod_r;
  logic [MASS_W-1:0]   ppm_r;
  logic [MINTOL_W-1:0] mint_r;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_st_r, out_st_nxt;
  logic [PCNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic [MASS_W-1:0]   out_m_r, out_m_nxt;
  logic [INT_W-1:0]    out_i_r, out_i_nxt;

  logic              div_start, div_done;
  logic [MASS_W-1:0] div_q;

  // combinational helpers
  logic              accept, put_en, put_ovf;
  logic [MASS_W-1:0] put_m, put_i;
  logic [MASS_W-1:0] lq_m, eq_m, lq_i, eq_i;
  logic [MASS_W+1:0] d_pos, d_neg;
  logic [MASS_W-1:0] dist_new, dist_cur, tol_prod;
  logic              cap_ovf;

  tplm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (prod_r),
    .denom (sum_r),
    .done  (div_done),
    .quot  (div_q)
  );

  function automatic logic [MASS_W-1:0] absdiff(input logic [MASS_W-1:0] a,
                                                input logic [MASS_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign accept = in_valid && !in_stall;
  assign lq_m = list_q[ENT_W-1:INT_W];
  assign lq_i = list_q[INT_W-1:0];
  assign eq_m = env_q[ENT_W-1:INT_W];
  assign eq_i = env_q[INT_W-1:0];
  assign d_pos = {2'b00, eq_m} - {2'b00, lq_m};
  assign d_neg = {2'b00, lq_m} - {2'b00, eq_m};
  assign dist_new = absdiff(lq_m, em_r);
  assign dist_cur = absdiff(lm_r, em_r);
  assign tol_prod = prod_r[2*MASS_W-1:MASS_W];
  assign put_ovf = (32'(start_r) + 32'(len_r)) >= 32'(LIST_CAPACITY);
  assign cap_ovf = (32'(cnt_r) + 32'(n_r)) > 32'(LIST_CAPACITY);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    env_cnt_nxt = env_cnt_r;
    n_nxt       = n_r;
    first_nxt   = first_r;
    elast_nxt   = elast_r;
    tol_nxt     = tol_r;
    base_nxt    = base_r;
    k_nxt       = k_r;
    start_nxt   = start_r;
    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    len_nxt     = len_r;
    lm_nxt      = lm_r;
    li_nxt      = li_r;
    em_nxt      = em_r;
    ei_nxt      = ei_r;
    lo_nxt      = lo_r;
    sum_nxt     = sum_r;
    res_st_nxt  = res_st_r;
    res_m_nxt   = res_m_r;
    res_i_nxt   = res_i_r;
    mul_a_nxt   = mul_a_r;
    mul_b_nxt   = mul_b_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt  = out_st_r;
    out_cnt_nxt = out_cnt_r;
    out_m_nxt   = out_m_r;
    out_i_nxt   = out_i_r;
    div_start   = 1'b0;

    list_raddr = ADDR_W'(in_read_index);
    list_we    = 1'b0;
    list_waddr = ADDR_W'(base_r + k_r);
    list_wdata = env_q;
    env_raddr  = ENV_AW'(p2_r);
    env_we     = 1'b0;
    env_waddr  = ENV_AW'(env_cnt_r);
    scr_raddr  = ADDR_W'(k_r);
    put_en     = 1'b0;
    put_m      = lq_m;
    put_i      = lq_i;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_st_nxt = ST_OK;
          res_m_nxt  = '0;
          res_i_nxt  = '0;
          state_nxt  = S_FIN;
          case (in_opcode)
            OP_PEAK: begin
              if (env_cnt_r >= ENV_CW'(ENVELOPE_MAX)) begin
                res_st_nxt = ST_ENV_LONG;
                if (in_last_of_envelope) env_cnt_nxt = '0;
              end else begin
                env_we      = 1'b1;
                env_cnt_nxt = env_cnt_r + 1'b1;
                if (env_cnt_r == '0) first_nxt = in_peak_mass;
                if (in_last_of_envelope) begin
                  n_nxt       = env_cnt_r + 1'b1;
                  elast_nxt   = in_peak_mass;
                  env_cnt_nxt = '0;
                  mul_a_nxt   = (env_cnt_r == '0) ? in_peak_mass : first_r;
                  mul_b_nxt   = ppm_r;
                  state_nxt   = S_TOL1;
                end
              end
            end
            OP_READ: begin
              if (32'(in_read_index) < 32'(cnt_r)) state_nxt = S_RD;
              else res_st_nxt = ST_RANGE;
            end
            OP_CLEAR: begin
              cnt_nxt     = '0;
              env_cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_m_nxt = lq_m;
        res_i_nxt = lq_i;
        state_nxt = S_FIN;
      end
      S_TOL1: state_nxt = S_TOL2;
      S_TOL2: begin
        tol_nxt    = (tol_prod < MASS_W'(mint_r)) ? MASS_W'(mint_r) : tol_prod;
        list_raddr = ADDR_W'(cnt_r - 1'b1);
        state_nxt  = S_CHK1;
      end
      S_CHK1: begin
        list_raddr = '0;
        if (cnt_r == '0 || {1'b0, first_r} > ({1'b0, lq_m} + {1'b0, tol_r})) begin
          base_nxt = cnt_r;
          k_nxt    = '0;
          if (cap_ovf) begin
            res_st_nxt = ST_OVERFLOW;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_APP_R;
          end
        end else begin
          state_nxt = S_CHK2;
        end
      end
      S_CHK2: begin
        start_nxt = '0;
        if ({1'b0, lq_m} > ({1'b0, elast_r} + {1'b0, tol_r})) begin
          k_nxt = cnt_r - 1'b1;
          if (cap_ovf) begin
            res_st_nxt = ST_OVERFLOW;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_PRE_R;
          end
        end else if (first_r > lq_m && cnt_r > CNT_W'(1)) begin
          k_nxt     = CNT_W'(1);
          state_nxt = S_SCAN_R;
        end else begin
          state_nxt = S_M_INIT;
        end
      end
      S_APP_R: begin
        env_raddr = ENV_AW'(k_r);
        state_nxt = S_APP_W;
      end
      S_APP_W: begin
        list_we    = 1'b1;
        list_waddr = ADDR_W'(base_r + k_r);
        list_wdata = env_q;
        k_nxt      = k_r + 1'b1;
        if (k_r + 1'b1 == CNT_W'(n_r)) begin
          cnt_nxt   = cnt_r + CNT_W'(n_r);
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_APP_R;
        end
      end
      // shift the stored list up by the envelope length, top entry first
      S_PRE_R: begin
        list_raddr = ADDR_W'(k_r);
        state_nxt  = S_PRE_W;
      end
      S_PRE_W: begin
        list_we    = 1'b1;
        list_waddr = ADDR_W'(k_r + CNT_W'(n_r));
        list_wdata = list_q;
        if (k_r == '0) begin
          base_nxt  = '0;
          state_nxt = S_APP_R;
        end else begin
          k_nxt     = k_r - 1'b1;
          state_nxt = S_PRE_R;
        end
      end
      S_SCAN_R: begin
        list_raddr = ADDR_W'(k_r);
        state_nxt  = S_SCAN_U;
      end
      S_SCAN_U: begin
        if (lq_m <= first_r) start_nxt = k_r;
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 < cnt_r) state_nxt = S_SCAN_R;
        else state_nxt = S_M_INIT;
      end
      S_M_INIT: begin
        p1_nxt    = start_r;
        p2_nxt    = '0;
        len_nxt   = '0;
        state_nxt = S_M_HEAD;
      end
      S_M_HEAD: begin
        list_raddr = ADDR_W'(p1_r);
        env_raddr  = ENV_AW'(p2_r);
        k_nxt      = '0;
        if (p1_r < cnt_r && p2_r < n_r) state_nxt = S_M_DEC;
        else if (p2_r < n_r) state_nxt = S_TAILE;
        else if (p1_r < cnt_r) state_nxt = S_TAILL;
        else state_nxt = S_CP_R;
      end
      S_M_DEC: begin
        lm_nxt = lq_m;
        li_nxt = lq_i;
        em_nxt = eq_m;
        ei_nxt = eq_i;
        list_raddr = ADDR_W'(p1_r + 1'b1);
        if ($signed(d_pos) > $signed({2'b00, tol_r})) begin
          put_en = 1'b1;
          p1_nxt = p1_r + 1'b1;
          state_nxt = S_M_HEAD;
        end else if ($signed(d_neg) > $signed({2'b00, tol_r})) begin
          put_en = 1'b1;
          put_m  = eq_m;
          put_i  = eq_i;
          p2_nxt = p2_r + 1'b1;
          state_nxt = S_M_HEAD;
        end else if (p1_r + 1'b1 < cnt_r) begin
          state_nxt = S_M_NEAR;
        end else begin
          state_nxt = S_CMB0;
        end
      end
      // pass stored peaks that lie closer to the new peak
      S_M_NEAR: begin
        list_raddr = ADDR_W'(p1_r + CNT_W'(2));
        if (dist_new < dist_cur) begin
          put_en = 1'b1;
          put_m  = lm_r;
          put_i  = li_r;
          p1_nxt = p1_r + 1'b1;
          lm_nxt = lq_m;
          li_nxt = lq_i;
          if (32'(p1_r) + 32'd2 < 32'(cnt_r)) state_nxt = S_M_NEAR;
          else state_nxt = S_CMB0;
        end else begin
          state_nxt = S_CMB0;
        end
      end
      S_CMB0: begin
        sum_nxt = {1'b0, li_r} + {1'b0, ei_r};
        if (({1'b0, li_r} + {1'b0, ei_r}) == '0) begin
          put_en = 1'b1;
          put_m  = lm_r;
          put_i  = '0;
          p1_nxt = p1_r + 1'b1;
          p2_nxt = p2_r + 1'b1;
          state_nxt = S_M_HEAD;
        end else begin
          if (em_r < lm_r) begin
            lo_nxt    = em_r;
            mul_a_nxt = lm_r - em_r;
            mul_b_nxt = li_r;
          end else begin
            lo_nxt    = lm_r;
            mul_a_nxt = em_r - lm_r;
            mul_b_nxt = ei_r;
          end
          state_nxt = S_CMB1;
        end
      end
      S_CMB1: state_nxt = S_CMB2;
      S_CMB2: begin
        div_start = 1'b1;
        state_nxt = S_CMB3;
      end
      S_CMB3: begin
        if (div_done) begin
          put_en = 1'b1;
          put_m  = lo_r + div_q;
          put_i  = sum_r[INT_W] ? {INT_W{1'b1}} : sum_r[INT_W-1:0];
          p1_nxt = p1_r + 1'b1;
          p2_nxt = p2_r + 1'b1;
          state_nxt = S_M_HEAD;
        end
      end
      S_TAILE: begin
        put_en = 1'b1;
        put_m  = eq_m;
        put_i  = eq_i;
        p2_nxt = p2_r + 1'b1;
        state_nxt = S_M_HEAD;
      end
      S_TAILL: begin
        put_en = 1'b1;
        p1_nxt = p1_r + 1'b1;
        state_nxt = S_M_HEAD;
      end
      S_CP_R: begin
        scr_raddr = ADDR_W'(k_r);
        if (k_r < len_r) begin
          state_nxt = S_CP_W;
        end else begin
          cnt_nxt   = start_r + len_r;
          state_nxt = S_FIN;
        end
      end
      S_CP_W: begin
        list_we    = 1'b1;
        list_waddr = ADDR_W'(start_r + k_r);
        list_wdata = scr_q;
        k_nxt      = k_r + 1'b1;
        state_nxt  = S_CP_R;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = PCNT_W'(cnt_r);
          out_m_nxt     = res_m_r;
          out_i_nxt     = res_i_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // a put past capacity drops the whole merge
    if (put_en) begin
      if (put_ovf) begin
        res_st_nxt = ST_OVERFLOW;
        state_nxt  = S_FIN;
      end else begin
        len_nxt = len_r + 1'b1;
      end
    end
  end

  assign scr_we    = put_en && !put_ovf;
  assign scr_waddr = ADDR_W'(len_r);
  assign scr_wdata = {put_m, put_i};

  always_ff @(posedge clk) begin
    if (list_we) list_mem[list_waddr] <= list_wdata;
    list_q <= list_mem[list_raddr];
    if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
    scr_q <= scr_mem[scr_raddr];
    if (env_we) env_mem[env_waddr] <= {in_peak_mass, in_peak_intensity};
    env_q <= env_mem[env_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      env_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      ppm_r       <= PPM_RESET;
      mint_r      <= MINTOL_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      env_cnt_r   <= env_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PPM_FACTOR:    ppm_r  <= cfg_data;
          REG_MIN_TOLERANCE: mint_r <= cfg_data[MINTOL_W-1:0];
          default: ;
        endcase
      end
    end
    n_r      <= n_nxt;
    first_r  <= first_nxt;
    elast_r  <= elast_nxt;
    tol_r    <= tol_nxt;
    base_r   <= base_nxt;
    k_r      <= k_nxt;
    start_r  <= start_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    len_r    <= len_nxt;
    lm_r     <= lm_nxt;
    li_r     <= li_nxt;
    em_r     <= em_nxt;
    ei_r     <= ei_nxt;
    lo_r     <= lo_nxt;
    sum_r    <= sum_nxt;
    res_st_r <= res_st_nxt;
    res_m_r  <= res_m_nxt;
    res_i_r  <= res_i_nxt;
    mul_a_r  <= mul_a_nxt;
    mul_b_r  <= mul_b_nxt;
    prod_r   <= (2*MASS_W)'(mul_a_r) * (2*MASS_W)'(mul_b_r);
    out_st_r  <= out_st_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_m_r   <= out_m_nxt;
    out_i_r   <= out_i_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_st_r;
  assign out_point_count     = out_cnt_r;
  assign out_point_mass      = out_m_r;
  assign out_point_intensity = out_i_r;

endmodule
